FILE: rtl/core/btpc_pkg.sv
// Shared types, constants and the divider step for the pressure compensation unit.
package btpc_pkg;

   localparam int unsigned RAW_W    = 20;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned DVSR_W   = 31;
   localparam int unsigned DIV_BITS = 2;
   localparam int unsigned DIV_STAGES = WORD_W / DIV_BITS;

   localparam logic signed [25:0] T_FINE_OFS   = 26'sd128000;
   localparam logic [20:0]        P_RAW_FULL   = 21'd1048576;
   localparam logic [11:0]        P_SCALE      = 12'd3125;
   localparam logic signed [27:0] T_ROUND      = 28'sd128;
   localparam int unsigned        P1_OFS_SHIFT = 47;
   localparam logic [63:0]        P1_OFS       = 64'd1 << P1_OFS_SHIFT;

   typedef enum logic [1:0] {
      CSR_TEMP_CALIB = 2'd0,
      CSR_PRESS_A    = 2'd1,
      CSR_PRESS_B    = 2'd2,
      CSR_PRESS_C    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_temp;
      logic [RAW_W-1:0] raw_press;
   } req_type;

   typedef struct packed {
      logic signed [19:0] temp_centideg;
      logic [31:0]        press_q24_8;
      logic               press_valid;
   } rsp_type;

   typedef struct packed {
      logic [DVSR_W-1:0] rem;
      logic [WORD_W-1:0] aq;
      logic [DVSR_W-1:0] dvsr;
      logic              qneg;
      logic              valid;
      logic [19:0]       temp;
   } div_type;

   function automatic div_type div_step(input div_type d);
      div_type     n;
      logic [DVSR_W:0] r;
      n = d;
      for (int k = 0; k < DIV_BITS; k++) begin
         r = {n.rem, n.aq[WORD_W-1]};
         if (r >= {1'b0, n.dvsr}) begin
            r    = r - {1'b0, n.dvsr};
            n.aq = {n.aq[WORD_W-2:0], 1'b1};
         end else begin
            n.aq = {n.aq[WORD_W-2:0], 1'b0};
         end
         n.rem = r[DVSR_W-1:0];
      end
      return n;
   endfunction

endpackage

FILE: rtl/core/btpc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
module btpc_div import btpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_vld,
   input  div_type in_data,
   output logic    out_vld,
   output div_type out_data
);

   div_type                stg_ff [DIV_STAGES];
   div_type                stg_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]  vld_ff;
   logic [DIV_STAGES-1:0]  vld_in;

   always_comb begin
      stg_in[0] = div_step(in_data);
      for (int i = 1; i < DIV_STAGES; i++) begin
         stg_in[i] = div_step(stg_ff[i-1]);
      end
      vld_in = {vld_ff[DIV_STAGES-2:0], in_vld};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES-1];
   assign out_data = stg_ff[DIV_STAGES-1];

endmodule

FILE: rtl/core/baro_temp_pressure_compensation_unit.sv
// Top level of the barometric temperature and pressure compensation unit.
// One raw temperature/pressure beat enters per cycle and its result leaves in order;
// the rate is one beat per cycle, set by the fully pipelined datapath: 12 front stages for
// temperature and the 64-bit pressure terms, a 32-stage divider retiring two quotient bits
// per stage, 6 back stages for the second-order terms and the output register. A stall on
// the result side holds the whole pipeline; an empty input stage still takes a beat. The
// user writes calibration words via the csr_ port only with no beat in flight; unchecked.
module baro_temp_pressure_compensation_unit import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   typedef struct packed {
      logic signed [33:0] prod_a;
      logic signed [33:0] dd;
      logic [19:0]        raw_press;
   } s1_type;
   typedef struct packed {
      logic signed [22:0] ta;
      logic signed [37:0] prod_b;
      logic [19:0]        raw_press;
   } s2_type;
   typedef struct packed {
      logic signed [24:0] tf;
      logic [19:0]        raw_press;
   } s3_type;
   typedef struct packed {
      logic [19:0]        temp;
      logic signed [25:0] v1;
      logic [19:0]        raw_press;
   } s4_type;
   typedef struct packed {
      logic signed [51:0] sq;
      logic signed [41:0] m5;
      logic signed [41:0] m2;
      logic [19:0]        temp;
      logic [19:0]        raw_press;
   } s5_type;
   typedef struct packed {
      logic [63:0]        m6;
      logic [63:0]        m3;
      logic signed [41:0] m5;
      logic signed [41:0] m2;
      logic [19:0]        temp;
      logic [19:0]        raw_press;
   } s6_type;
   typedef struct packed {
      logic [63:0] v2;
      logic [63:0] xv;
      logic [20:0] np;
      logic [19:0] temp;
   } s7_type;
   typedef struct packed {
      logic [47:0] xlo;
      logic [31:0] xhi;
      logic [63:0] yv;
      logic [19:0] temp;
   } s8_type;
   typedef struct packed {
      logic [30:0] dv;
      logic [43:0] ylo;
      logic [31:0] yhi;
      logic [19:0] temp;
   } s9_type;
   typedef struct packed {
      logic [63:0] nv;
      logic [30:0] dv;
      logic [19:0] temp;
   } s10_type;
   typedef struct packed {
      logic [63:0] p;
      logic        valid;
      logic [19:0] temp;
   } s12_type;
   typedef struct packed {
      logic [63:0]        ll;
      logic [31:0]        lh;
      logic signed [48:0] pl8;
      logic [31:0]        ph8;
      logic [63:0]        p;
      logic               valid;
      logic [19:0]        temp;
   } s13_type;
   typedef struct packed {
      logic [63:0] x;
      logic [63:0] bt;
      logic [63:0] p;
      logic        valid;
      logic [19:0] temp;
   } s14_type;
   typedef struct packed {
      logic signed [48:0] xl9;
      logic [31:0]        xh9;
      logic [63:0]        bt;
      logic [63:0]        p;
      logic               valid;
      logic [19:0]        temp;
   } s15_type;
   typedef struct packed {
      logic [63:0] at;
      logic [63:0] bt;
      logic [63:0] p;
      logic        valid;
      logic [19:0] temp;
   } s16_type;
   typedef struct packed {
      logic [63:0] sum;
      logic        valid;
      logic [19:0] temp;
   } s17_type;

   logic [47:0] temp_calib_ff, temp_calib_in;
   logic [63:0] press_a_ff, press_a_in;
   logic [63:0] press_b_ff, press_b_in;
   logic [15:0] press_c_ff, press_c_in;

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0]        p8_32, p9_32;

   logic        adv, en0;
   logic [17:0] vld_ff, vld_in;
   logic        rsp_vld_ff;
   logic        div_vld;
   div_type     div_out;

   req_type s0_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s7_type  s7_ff, s7_in;
   s8_type  s8_ff, s8_in;
   s9_type  s9_ff, s9_in;
   s10_type s10_ff, s10_in;
   div_type s11_ff, s11_in;
   s12_type s12_ff, s12_in;
   s13_type s13_ff, s13_in;
   s14_type s14_ff, s14_in;
   s15_type s15_ff, s15_in;
   s16_type s16_ff, s16_in;
   s17_type s17_ff, s17_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [17:0] xa;
   logic signed [16:0] dt;
   logic signed [27:0] t5;
   logic signed [67:0] m6_full, m3_full;
   logic [63:0]        m3_sh, px, s13_s, pb, ax, sum_sh, fin;

   // calibration registers
   always_comb begin
      temp_calib_in = temp_calib_ff;
      press_a_in    = press_a_ff;
      press_b_in    = press_b_ff;
      press_c_in    = press_c_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_CALIB: temp_calib_in = csr_wdata[47:0];
            CSR_PRESS_A:    press_a_in    = csr_wdata;
            CSR_PRESS_B:    press_b_in    = csr_wdata;
            CSR_PRESS_C:    press_c_in    = csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
      end else begin
         temp_calib_ff <= temp_calib_in;
         press_a_ff    <= press_a_in;
         press_b_ff    <= press_b_in;
         press_c_ff    <= press_c_in;
      end
   end

   assign t1 = temp_calib_ff[15:0];
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_a_ff[63:48];
   assign p5 = press_b_ff[15:0];
   assign p6 = press_b_ff[31:16];
   assign p7 = press_b_ff[47:32];
   assign p8 = press_b_ff[63:48];
   assign p9 = press_c_ff;
   assign p8_32 = {{16{p8[15]}}, p8};
   assign p9_32 = {{16{p9[15]}}, p9};

   // flow control
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign en0       = adv || !vld_ff[0];
   assign req_ready = en0;
   assign vld_in    = {vld_ff[16:12], div_vld, vld_ff[10:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (en0) begin
            vld_ff[0] <= vld_in[0];
         end
         if (adv) begin
            vld_ff[17:1] <= vld_in[17:1];
            rsp_vld_ff   <= vld_ff[17];
         end
      end
   end

   // datapath
   always_comb begin
      xa = $signed({1'b0, s0_ff.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
      dt = $signed({1'b0, s0_ff.raw_temp[19:4]}) - $signed({1'b0, t1});
      s1_in.prod_a    = xa * t2;
      s1_in.dd        = dt * dt;
      s1_in.raw_press = s0_ff.raw_press;

      s2_in.ta        = s1_ff.prod_a[33:11];
      s2_in.prod_b    = $signed(s1_ff.dd[33:12]) * t3;
      s2_in.raw_press = s1_ff.raw_press;

      s3_in.tf        = s2_ff.ta + $signed(s2_ff.prod_b[37:14]);
      s3_in.raw_press = s2_ff.raw_press;

      t5              = s3_ff.tf * 28'sd5 + T_ROUND;
      s4_in.temp      = t5[27:8];
      s4_in.v1        = s3_ff.tf - T_FINE_OFS;
      s4_in.raw_press = s3_ff.raw_press;

      s5_in.sq        = s4_ff.v1 * s4_ff.v1;
      s5_in.m5        = s4_ff.v1 * p5;
      s5_in.m2        = s4_ff.v1 * p2;
      s5_in.temp      = s4_ff.temp;
      s5_in.raw_press = s4_ff.raw_press;

      m6_full         = s5_ff.sq * p6;
      m3_full         = s5_ff.sq * p3;
      s6_in.m6        = m6_full[63:0];
      s6_in.m3        = m3_full[63:0];
      s6_in.m5        = s5_ff.m5;
      s6_in.m2        = s5_ff.m2;
      s6_in.temp      = s5_ff.temp;
      s6_in.raw_press = s5_ff.raw_press;

      m3_sh      = $signed(s6_ff.m3) >>> 8;
      s7_in.v2   = s6_ff.m6 + ({{22{s6_ff.m5[41]}}, s6_ff.m5} << 17)
                   + ({{48{p4[15]}}, p4} << 35);
      s7_in.xv   = m3_sh + ({{22{s6_ff.m2[41]}}, s6_ff.m2} << 12) + P1_OFS;
      s7_in.np   = P_RAW_FULL - {1'b0, s6_ff.raw_press};
      s7_in.temp = s6_ff.temp;

      s8_in.xlo  = s7_ff.xv[31:0] * p1;
      s8_in.xhi  = s7_ff.xv[63:32] * {16'b0, p1};
      s8_in.yv   = {12'b0, s7_ff.np, 31'b0} - s7_ff.v2;
      s8_in.temp = s7_ff.temp;

      px         = {s8_ff.xhi, 32'b0} + {16'b0, s8_ff.xlo};
      s9_in.dv   = px[63:33];
      s9_in.ylo  = s8_ff.yv[31:0] * P_SCALE;
      s9_in.yhi  = s8_ff.yv[63:32] * {20'b0, P_SCALE};
      s9_in.temp = s8_ff.temp;

      s10_in.nv   = {s9_ff.yhi, 32'b0} + {20'b0, s9_ff.ylo};
      s10_in.dv   = s9_ff.dv;
      s10_in.temp = s9_ff.temp;

      s11_in.rem   = '0;
      s11_in.aq    = s10_ff.nv[63] ? (64'd0 - s10_ff.nv) : s10_ff.nv;
      s11_in.dvsr  = s10_ff.dv[30] ? (31'd0 - s10_ff.dv) : s10_ff.dv;
      s11_in.qneg  = s10_ff.nv[63] ^ s10_ff.dv[30];
      s11_in.valid = |s10_ff.dv;
      s11_in.temp  = s10_ff.temp;

      s12_in.p     = div_out.qneg ? (64'd0 - div_out.aq) : div_out.aq;
      s12_in.valid = div_out.valid;
      s12_in.temp  = div_out.temp;

      s13_s        = $signed(s12_ff.p) >>> 13;
      s13_in.ll    = s13_s[31:0] * s13_s[31:0];
      s13_in.lh    = s13_s[31:0] * s13_s[63:32];
      s13_in.pl8   = $signed({1'b0, s12_ff.p[31:0]}) * p8;
      s13_in.ph8   = s12_ff.p[63:32] * p8_32;
      s13_in.p     = s12_ff.p;
      s13_in.valid = s12_ff.valid;
      s13_in.temp  = s12_ff.temp;

      pb           = {{15{s13_ff.pl8[48]}}, s13_ff.pl8} + {s13_ff.ph8, 32'b0};
      s14_in.x     = s13_ff.ll + {s13_ff.lh[30:0], 33'b0};
      s14_in.bt    = $signed(pb) >>> 19;
      s14_in.p     = s13_ff.p;
      s14_in.valid = s13_ff.valid;
      s14_in.temp  = s13_ff.temp;

      s15_in.xl9   = $signed({1'b0, s14_ff.x[31:0]}) * p9;
      s15_in.xh9   = s14_ff.x[63:32] * p9_32;
      s15_in.bt    = s14_ff.bt;
      s15_in.p     = s14_ff.p;
      s15_in.valid = s14_ff.valid;
      s15_in.temp  = s14_ff.temp;

      ax           = {{15{s15_ff.xl9[48]}}, s15_ff.xl9} + {s15_ff.xh9, 32'b0};
      s16_in.at    = $signed(ax) >>> 25;
      s16_in.bt    = s15_ff.bt;
      s16_in.p     = s15_ff.p;
      s16_in.valid = s15_ff.valid;
      s16_in.temp  = s15_ff.temp;

      s17_in.sum   = s16_ff.p + s16_ff.at + s16_ff.bt;
      s17_in.valid = s16_ff.valid;
      s17_in.temp  = s16_ff.temp;

      sum_sh = $signed(s17_ff.sum) >>> 8;
      fin    = sum_sh + ({{48{p7[15]}}, p7} << 4);
      rsp_in.temp_centideg = s17_ff.temp;
      rsp_in.press_valid   = s17_ff.valid;
      if (!s17_ff.valid || fin[63]) begin
         rsp_in.press_q24_8 = '0;
      end else if (|fin[63:32]) begin
         rsp_in.press_q24_8 = '1;
      end else begin
         rsp_in.press_q24_8 = fin[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         s0_ff <= req_data;
      end
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         s12_ff <= s12_in;
         s13_ff <= s13_in;
         s14_ff <= s14_in;
         s15_ff <= s15_in;
         s16_ff <= s16_in;
         s17_ff <= s17_in;
         rsp_ff <= rsp_in;
      end
   end

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (vld_ff[11]),
      .in_data  (s11_ff),
      .out_vld  (div_vld),
      .out_data (div_out)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.press_valid) |-> (rsp_ff.press_q24_8 == 32'd0))
      else $error("pressure not zero on zero divisor");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[17:1]))
      else $error("pipeline moved during stall");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !adv) |=> vld_ff[0])
      else $error("input stage dropped a beat");

endmodule

FILE: tb/baro_temp_pressure_compensation_unit_checker.sv
// Checker for the compensation unit: tracks calibration, predicts each result and compares.
module baro_temp_pressure_compensation_unit_checker import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] temp_cal, press_a, press_b;
   logic [15:0] press_c;
   rsp_type     compensated_q[$];

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr(input logic [63:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] quot_trunc(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q  = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic rsp_type compensate(input req_type r);
      rsp_type     o;
      logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] d, a, b, tf, t, v1, v2, p;
      adc_t = 64'(r.raw_temp);
      adc_p = 64'(r.raw_press);
      t1 = 64'(temp_cal[15:0]);
      t2 = sext16(temp_cal[31:16]);
      t3 = sext16(temp_cal[47:32]);
      p1 = 64'(press_a[15:0]);
      p2 = sext16(press_a[31:16]);
      p3 = sext16(press_a[47:32]);
      p4 = sext16(press_a[63:48]);
      p5 = sext16(press_b[15:0]);
      p6 = sext16(press_b[31:16]);
      p7 = sext16(press_b[47:32]);
      p8 = sext16(press_b[63:48]);
      p9 = sext16(press_c);
      a  = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d  = (adc_t >> 4) - t1;
      b  = asr(asr(d * d, 12) * t3, 14);
      tf = a + b;
      t  = asr(tf * 64'd5 + 64'd128, 8);
      if ($signed(t) < -64'sd524288) o.temp_centideg = 20'h80000;
      else if ($signed(t) > 64'sd524287) o.temp_centideg = 20'h7FFFF;
      else o.temp_centideg = t[19:0];
      v1 = tf - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      o.press_q24_8 = '0;
      o.press_valid = 1'b0;
      if (v1 != 0) begin
         o.press_valid = 1'b1;
         p = 64'd1048576 - adc_p;
         p = quot_trunc(((p << 31) - v2) * 64'd3125, v1);
         a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
         b = asr(p8 * p, 19);
         p = asr(p + a + b, 8) + (p7 << 4);
         if (p[63]) o.press_q24_8 = '0;
         else if (p > 64'hFFFF_FFFF) o.press_q24_8 = 32'hFFFF_FFFF;
         else o.press_q24_8 = p[31:0];
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         temp_cal <= '0;
         press_a  <= '0;
         press_b  <= '0;
         press_c  <= '0;
         compensated_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TEMP_CALIB: temp_cal <= {16'd0, csr_wdata[47:0]};
               CSR_PRESS_A:    press_a  <= csr_wdata;
               CSR_PRESS_B:    press_b  <= csr_wdata;
               CSR_PRESS_C:    press_c  <= csr_wdata[15:0];
            endcase
         end
         if (req_valid && req_ready) compensated_q.push_back(compensate(req_data));
         if (rsp_valid && rsp_ready) begin
            if (compensated_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = compensated_q.pop_front();
               if (want.temp_centideg !== rsp_data.temp_centideg) begin
                  $display("%0t: temp_centideg expected %0d actual %0d", $time,
                           want.temp_centideg, rsp_data.temp_centideg);
                  fail_count++;
               end
               if (want.press_q24_8 !== rsp_data.press_q24_8) begin
                  $display("%0t: press_q24_8 expected %0h actual %0h", $time,
                           want.press_q24_8, rsp_data.press_q24_8);
                  fail_count++;
               end
               if (want.press_valid !== rsp_data.press_valid) begin
                  $display("%0t: press_valid expected %0b actual %0b", $time,
                           want.press_valid, rsp_data.press_valid);
                  fail_count++;
               end
            end
         end
      end
      pending <= compensated_q.size();
   end
endmodule

FILE: tb/baro_temp_pressure_compensation_unit_test.sv
// Top of the compensation unit regression: clock, reset, stimulus and verdict.
module baro_temp_pressure_compensation_unit_test import btpc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN = 60;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_TEMP_CALIB;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending;
   logic        no_idle = 1'b0;
   logic        rsp_fire = 1'b0;
   int          rsp_hold = 0;
   int          quiet = 0;

   baro_temp_pressure_compensation_unit dut (.*);
   baro_temp_pressure_compensation_unit_checker chk (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_fire <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_fire) rsp_hold = no_idle ? 0 : $urandom_range(0, 9);
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("baro_temp_pressure_compensation_unit regression: fail");
         $finish;
      end
   end

   task automatic send(input logic [19:0] rt, input logic [19:0] rp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{raw_temp: rt, raw_press: rp};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic calibrate(input logic [63:0] tc, pa, pb, input logic [15:0] pc);
      write_csr(CSR_TEMP_CALIB, tc);
      write_csr(CSR_PRESS_A, pa);
      write_csr(CSR_PRESS_B, pb);
      write_csr(CSR_PRESS_C, {48'd0, pc});
   endtask

   // typical factory calibration
   localparam logic [63:0] TYP_T = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] TYP_C = 16'd6000;

   function automatic logic [63:0] nudge(input logic [63:0] w);
      logic [63:0] r;
      for (int k = 0; k < 4; k++) r[k*16 +: 16] = w[k*16 +: 16] + 16'($urandom_range(0, 511)) - 16'd256;
      return r;
   endfunction

   initial begin
      logic [63:0] ta, pa, pb;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset calibration: zero divisor
      send(20'd519888, 20'd415148);
      send(20'hFFFFF, 20'h00000);
      drain();

      calibrate(TYP_T, TYP_A, TYP_B, TYP_C);
      send(20'd519888, 20'd415148);
      send(20'd0, 20'd0);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'd0, 20'hFFFFF);
      send(20'hFFFFF, 20'd0);
      send(20'd440080, 20'd1);
      send(20'd600000, 20'd300000);
      drain();

      calibrate('1, '1, '1, 16'hFFFF);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'd0, 20'd0);
      send(20'd524288, 20'd524288);
      drain();

      calibrate({16'd0, 16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
      send(20'hFFFFF, 20'h00000);
      send(20'd0, 20'hFFFFF);
      send(20'd12345, 20'd54321);
      drain();

      calibrate({16'd0, 16'h7FFF, 16'h7FFF, 16'd0}, {4{16'h7FFF}} & 64'hFFFF_FFFF_FFFF_0000,
                {4{16'h7FFF}}, 16'h7FFF);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'd0, 20'd0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 3 == 2) begin
            ta = {$urandom, $urandom};
            pa = {$urandom, $urandom};
            pb = {$urandom, $urandom};
         end else begin
            ta = nudge(TYP_T);
            pa = nudge(TYP_A);
            pb = nudge(TYP_B);
         end
         calibrate(ta, pa, pb, 16'($urandom));
         no_idle = (ph == 1);
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 3) == 0) send(20'($urandom), 20'($urandom));
            else send(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 500000)));
         end
         drain();
         no_idle = 1'b0;
      end

      if (fail_count == 0)
         $display("baro_temp_pressure_compensation_unit regression: pass");
      else
         $display("baro_temp_pressure_compensation_unit regression: fail");
      $finish;
   end
endmodule
